[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("checker assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   `ASSERT_AT(label, clk, rst, (ante) |=> (cons))

`endif

[rtl/egsc_pkg.sv]
// Package with the types, constants and codes of the EMG gesture servo controller.
package egsc_pkg;

   localparam int PULSE_MIN_DEFAULT = 150;
   localparam int PULSE_MAX_DEFAULT = 600;

   localparam int NUM_FINGERS = 5;
   localparam int NUM_SLOTS   = 3;
   localparam int IDX_W       = 3;
   localparam logic [IDX_W-1:0] LAST_FINGER = IDX_W'(NUM_FINGERS - 1);
   localparam logic [IDX_W-1:0] LAST_SCORE  = IDX_W'(NUM_SLOTS - 1);

   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_TICK   = 1'b1;
   localparam logic [7:0] EMG_TYPE = 8'd32;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENSOR_ID_A  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENSOR_ID_B  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENSOR_ID_C  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_ANGLE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOSED_ANGLE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_ANGLE   = 3'd5;

   localparam logic [31:0] SENSOR_ID_A_RESET  = 32'd4294963881;
   localparam logic [31:0] SENSOR_ID_B_RESET  = 32'd4294943100;
   localparam logic [31:0] SENSOR_ID_C_RESET  = 32'd28358;
   localparam logic [7:0]  OPEN_ANGLE_RESET   = 8'd30;
   localparam logic [7:0]  CLOSED_ANGLE_RESET = 8'd150;
   localparam logic [6:0]  STEP_ANGLE_RESET   = 7'd15;
   localparam logic [7:0]  ANGLE_RESET        = 8'd30;
   localparam logic [7:0]  ANGLE_TOP          = 8'd180;

   // Floor division by 180 is exact for products below 2**20 with this reciprocal.
   localparam int PROD_W       = 20;
   localparam int RECIP_W      = 21;
   localparam int QPROD_W      = PROD_W + RECIP_W;
   localparam int DIV180_SHIFT = 28;
   localparam int QUOT_W       = QPROD_W - DIV180_SHIFT;
   localparam logic [RECIP_W-1:0] DIV180_RECIP = 21'd1491309;

   typedef struct packed {
      logic        op;
      logic [31:0] unit_id;
      logic [7:0]  packet_type;
      logic [7:0]  level;
      logic [7:0]  level_copy;
   } egsc_req_type;

   typedef struct packed {
      logic [9:0] pulse_finger0;
      logic [9:0] pulse_finger1;
      logic [9:0] pulse_finger2;
      logic [9:0] pulse_finger3;
      logic [9:0] pulse_finger4;
   } egsc_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STEP,
      ST_PULSE_MUL,
      ST_PULSE_LOAD,
      ST_EMIT,
      ST_SMOOTH,
      ST_SCORE_PQ,
      ST_SCORE_MUL,
      ST_SCORE_CMP
   } egsc_state_type;

   typedef struct packed {
      logic             take_packet;
      logic             step_angles;
      logic             pulse_mul;
      logic             pulse_load;
      logic             emit;
      logic             smooth;
      logic             score_pq;
      logic             score_mul;
      logic             score_cmp;
      logic [IDX_W-1:0] idx;
   } egsc_cmd_type;

   typedef struct packed {
      logic out_free;
   } egsc_status_type;

endpackage

[rtl/egsc_ctrl.sv]
// Controller state machine that sequences packets and update ticks.
module egsc_ctrl
   import egsc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_op,
   output logic            req_ready,
   input  egsc_status_type status,
   output egsc_cmd_type    cmd
);

   egsc_state_type   state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             idx_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign idx_last = (state_ff == ST_PULSE_LOAD) ? (idx_ff == LAST_FINGER)
                                                 : (idx_ff == LAST_SCORE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_op == OP_TICK)) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP:       state_in = ST_PULSE_MUL;
         ST_PULSE_MUL:  state_in = ST_PULSE_LOAD;
         ST_PULSE_LOAD: state_in = idx_last ? ST_EMIT : ST_PULSE_MUL;
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_SMOOTH;
            end
         end
         ST_SMOOTH:     state_in = ST_SCORE_PQ;
         ST_SCORE_PQ:   state_in = ST_SCORE_MUL;
         ST_SCORE_MUL:  state_in = ST_SCORE_CMP;
         ST_SCORE_CMP:  state_in = idx_last ? ST_IDLE : ST_SCORE_PQ;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      unique case (state_ff)
         ST_PULSE_LOAD, ST_SCORE_CMP: idx_in = idx_last ? '0 : idx_ff + IDX_W'(1);
         ST_PULSE_MUL, ST_SCORE_PQ, ST_SCORE_MUL: idx_in = idx_ff;
         default: idx_in = '0;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.idx   = idx_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.take_packet = req_valid && (req_op == OP_PACKET);
         end
         ST_STEP:       cmd.step_angles = 1'b1;
         ST_PULSE_MUL:  cmd.pulse_mul   = 1'b1;
         ST_PULSE_LOAD: cmd.pulse_load  = 1'b1;
         ST_EMIT:       cmd.emit        = status.out_free;
         ST_SMOOTH:     cmd.smooth      = 1'b1;
         ST_SCORE_PQ:   cmd.score_pq    = 1'b1;
         ST_SCORE_MUL:  cmd.score_mul   = 1'b1;
         ST_SCORE_CMP:  cmd.score_cmp   = 1'b1;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

[rtl/egsc_dp.sv]
// Datapath with the registers, finger stepping, pulse scaling, smoothing and scoring.
module egsc_dp
   import egsc_pkg::*;
#(
   parameter int PULSE_MIN = PULSE_MIN_DEFAULT,
   parameter int PULSE_MAX = PULSE_MAX_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  egsc_req_type           req_data,
   input  egsc_cmd_type           cmd,
   output egsc_status_type        status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output egsc_rsp_type           rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PULSE_DIFF = PULSE_MAX - PULSE_MIN;
   localparam bit DIFF_NEG = (PULSE_DIFF < 0);
   localparam logic [11:0] DIFF_MAG = 12'(DIFF_NEG ? -PULSE_DIFF : PULSE_DIFF);
   localparam logic signed [13:0] MIN_S = 14'(PULSE_MIN);
   localparam logic signed [13:0] PULSE_TOP = 14'sd1023;

   localparam logic [23:0] W_KEEP = 24'd179;
   localparam logic [23:0] W_NEW  = 24'd19712;
   localparam logic [23:0] ROUND  = 24'd128;

   localparam logic [20:0] BASE_HI = 21'd51200;
   localparam logic [20:0] BASE_LO = 21'd38400;
   localparam int DEN_W = 42;
   localparam int N400_W = 41;

   localparam logic [1:0] SCORE_A = 2'd0;
   localparam logic [1:0] SCORE_B = 2'd1;
   localparam logic [1:0] SCORE_C = 2'd2;

   logic [31:0] sensor_id_ff [NUM_SLOTS];
   logic [7:0]  open_ff, closed_ff;
   logic [6:0]  step_ff;
   logic [7:0]  latest_ff [NUM_SLOTS];
   logic [15:0] smooth_ff [NUM_SLOTS];
   logic [7:0]  target_ff [NUM_FINGERS];
   logic [7:0]  cur_ff [NUM_FINGERS];

   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [QPROD_W-1:0] qprod;
   logic [QUOT_W-1:0]  quot;
   logic signed [13:0] pulse_s;
   logic [9:0]         pulse_val;
   logic [9:0]         pulse_ff [NUM_FINGERS];

   egsc_rsp_type rsp_data_ff;
   logic         rsp_valid_ff, rsp_valid_in;

   logic [31:0]       pkt_id;
   logic [15:0]       x_sel;
   logic [20:0]       p_sel, q_sel;
   logic [20:0]       p_ff, q_ff;
   logic [31:0]       sq_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [N400_W-1:0] n400_ff;
   logic              open_hit, close_hit;
   logic [7:0]        new_target;

   function automatic logic [7:0] step_toward(logic [7:0] cur, logic [7:0] tgt,
                                              logic [6:0] stp);
      logic signed [10:0] c, t, s, c_up, c_dn;
      c = signed'({3'b000, cur});
      t = signed'({3'b000, tgt});
      s = signed'({4'b0000, stp});
      c_up = (((c <<< 1) + s) < (t <<< 1)) ? (c + s) : c;
      c_dn = ((c_up <<< 1) > ((t <<< 1) + s)) ? (c_up - s) : c_up;
      if (c_dn < 11'sd0) begin
         return 8'd0;
      end else if (c_dn > signed'({3'b000, ANGLE_TOP})) begin
         return ANGLE_TOP;
      end
      return c_dn[7:0];
   endfunction

   function automatic logic [15:0] smooth_level(logic [15:0] v, logic [7:0] lvl);
      logic [23:0] acc;
      acc = 24'(v) * W_KEEP + 24'(lvl) * W_NEW + ROUND;
      return acc[23:8];
   endfunction

   // An invalid packet counts as coming from sensor ID zero.
   assign pkt_id = ((req_data.packet_type == EMG_TYPE) &&
                    (req_data.level == req_data.level_copy)) ? req_data.unit_id : 32'd0;

   assign prod_in = PROD_W'(cur_ff[cmd.idx]) * PROD_W'(DIFF_MAG);
   assign qprod   = QPROD_W'(prod_ff) * QPROD_W'(DIV180_RECIP);
   assign quot    = qprod[DIV180_SHIFT +: QUOT_W];
   assign pulse_s = DIFF_NEG ? (MIN_S - signed'({1'b0, quot}))
                             : (MIN_S + signed'({1'b0, quot}));

   always_comb begin
      if (pulse_s < 14'sd0) begin
         pulse_val = 10'd0;
      end else if (pulse_s > PULSE_TOP) begin
         pulse_val = 10'd1023;
      end else begin
         pulse_val = pulse_s[9:0];
      end
   end

   always_comb begin
      unique case (cmd.idx[1:0])
         SCORE_A: begin
            x_sel = smooth_ff[0];
            p_sel = 21'(smooth_ff[1]) * 21'd3 + BASE_HI;
            q_sel = 21'(smooth_ff[2]) * 21'd13 + BASE_LO;
         end
         SCORE_B: begin
            x_sel = smooth_ff[1];
            p_sel = 21'(smooth_ff[0]) * 21'd20 + BASE_HI;
            q_sel = 21'(smooth_ff[2]) * 21'd20 + BASE_HI;
         end
         SCORE_C: begin
            x_sel = smooth_ff[2];
            p_sel = 21'(smooth_ff[0]) * 21'd12 + BASE_HI;
            q_sel = 21'(smooth_ff[1]) * 21'd5 + BASE_LO;
         end
         default: begin
            x_sel = '0;
            p_sel = '0;
            q_sel = '0;
         end
      endcase
   end

   assign open_hit   = {n400_ff, 1'b0} < den_ff;
   assign close_hit  = DEN_W'(n400_ff) > den_ff;
   assign new_target = open_hit ? open_ff : closed_ff;

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_id_ff[0] <= SENSOR_ID_A_RESET;
         sensor_id_ff[1] <= SENSOR_ID_B_RESET;
         sensor_id_ff[2] <= SENSOR_ID_C_RESET;
         open_ff         <= OPEN_ANGLE_RESET;
         closed_ff       <= CLOSED_ANGLE_RESET;
         step_ff         <= STEP_ANGLE_RESET;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            latest_ff[i] <= '0;
            smooth_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_FINGERS; i++) begin
            target_ff[i] <= ANGLE_RESET;
            cur_ff[i]    <= ANGLE_RESET;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_SENSOR_ID_A:  sensor_id_ff[0] <= csr_wdata;
               CSR_SENSOR_ID_B:  sensor_id_ff[1] <= csr_wdata;
               CSR_SENSOR_ID_C:  sensor_id_ff[2] <= csr_wdata;
               CSR_OPEN_ANGLE:   open_ff         <= csr_wdata[7:0];
               CSR_CLOSED_ANGLE: closed_ff       <= csr_wdata[7:0];
               CSR_STEP_ANGLE:   step_ff         <= csr_wdata[6:0];
               default: begin
               end
            endcase
         end
         if (cmd.take_packet) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (pkt_id == sensor_id_ff[i]) begin
                  latest_ff[i] <= req_data.level;
               end
            end
         end
         if (cmd.step_angles) begin
            for (int i = 0; i < NUM_FINGERS; i++) begin
               cur_ff[i] <= step_toward(cur_ff[i], target_ff[i], step_ff);
            end
         end
         if (cmd.smooth) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               smooth_ff[i] <= smooth_level(smooth_ff[i], latest_ff[i]);
            end
         end
         if (cmd.score_cmp && (open_hit || close_hit)) begin
            unique case (cmd.idx[1:0])
               SCORE_A: begin
                  target_ff[3] <= new_target;
                  target_ff[4] <= new_target;
               end
               SCORE_B: begin
                  target_ff[1] <= new_target;
                  target_ff[2] <= new_target;
               end
               SCORE_C: target_ff[0] <= new_target;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pulse_mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.pulse_load) begin
         pulse_ff[cmd.idx] <= pulse_val;
      end
      if (cmd.emit) begin
         rsp_data_ff.pulse_finger0 <= pulse_ff[0];
         rsp_data_ff.pulse_finger1 <= pulse_ff[1];
         rsp_data_ff.pulse_finger2 <= pulse_ff[2];
         rsp_data_ff.pulse_finger3 <= pulse_ff[3];
         rsp_data_ff.pulse_finger4 <= pulse_ff[4];
      end
      if (cmd.score_pq) begin
         p_ff  <= p_sel;
         q_ff  <= q_sel;
         sq_ff <= 32'(x_sel) * 32'(x_sel);
      end
      if (cmd.score_mul) begin
         den_ff  <= DEN_W'(p_ff) * DEN_W'(q_ff);
         n400_ff <= N400_W'(sq_ff) * N400_W'(400);
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

[rtl/emg_gesture_servo_controller.sv]
// Top level of the EMG gesture servo controller.
// A radio packet beat is taken while idle and yields no result; an update tick
// holds the input side busy while it steps the five fingers, passes each finger in
// turn through the shared multiply-by-reciprocal pulse scaler, loads the output
// register (waiting while the previous result beat has not been taken), smooths
// the three levels and passes each score through the shared square and product
// unit. The result beat is offered from the output register once it is loaded,
// and waits there while the next items are accepted.
module emg_gesture_servo_controller
   import egsc_pkg::*;
#(
   parameter int PULSE_MIN = PULSE_MIN_DEFAULT,
   parameter int PULSE_MAX = PULSE_MAX_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  egsc_req_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output egsc_rsp_type           rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   egsc_cmd_type    cmd;
   egsc_status_type status;

   egsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   egsc_dp #(
      .PULSE_MIN (PULSE_MIN),
      .PULSE_MAX (PULSE_MAX)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

endmodule

[rtl/egsc_checker.sv]
// Port checker for the EMG gesture servo controller and its bind statement.
`include "assert_macros.svh"

module egsc_checker
   import egsc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input egsc_req_type           req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input egsc_rsp_type           rsp_data
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `ASSERT_NEXT(a_tick_busy, clock, reset, req_valid && req_ready && (req_data.op == OP_TICK), !req_ready)
   `ASSERT_NEXT(a_packet_free, clock, reset, req_valid && req_ready && (req_data.op == OP_PACKET), req_ready)
   `ASSERT_AT(a_rsp_from_tick, clock, reset, $rose(rsp_valid) |-> (!req_ready && $past(!req_ready)))

endmodule

bind emg_gesture_servo_controller egsc_checker u_egsc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_data     (req_data),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_data     (rsp_data)
);
